@@ design/bbps_pkg.sv @@
// ----------------------------------------------------------------------------
// bbps_pkg: shared types and constants for the branch-and-bound path search
// Widths of the fixed fields, default parameter values and the sequencer state.
// ----------------------------------------------------------------------------
`default_nettype none
package bbps_pkg;
    localparam int MAX_CITIES_DEF = 16;
    localparam int DIST_BITS_DEF  = 16;
    localparam int LEN_W          = 20;
    localparam int CNT_W          = 32;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [0:0] CFG_CITY_COUNT    = 1'b0;
    localparam logic [0:0] CFG_INITIAL_BOUND = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXAM,
        ST_EMIT
    } state_t;
endpackage
`default_nettype wire

@@ design/branch_bound_path_search.sv @@
// ----------------------------------------------------------------------------
// branch_bound_path_search: depth-first branch-and-bound shortest open path
// Load beats fill the neighbour table; a start beat searches from city 0 and
// streams out the best path, one city per result strobe (one strobe if none found).
// ----------------------------------------------------------------------------
// Sequencing: a load beat is taken while idle; busy stays low. A start beat
// keeps busy high: FETCH then EXAM (read, then add/compare) per table entry
// tried, a FETCH per exhausted node including the root, then EMIT per result
// strobe. Throughput: one search at a time; results cannot be stalled.
// Reset: control state and stacks cleared, config to 16 cities and LEN_MAX;
// the neighbour table is undefined until written (no clearing pass).
`default_nettype none
module branch_bound_path_search #(
    parameter int MAX_CITIES = bbps_pkg::MAX_CITIES_DEF,
    parameter int DIST_BITS  = bbps_pkg::DIST_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [19:0]               cfg_data,
    // command
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      op,
    input  wire logic [3:0]                from_city,
    input  wire logic [3:0]                rank,
    input  wire logic [3:0]                to_city,
    input  wire logic [15:0]               edge_length,
    // results
    output logic                           result_valid,
    output logic                           found,
    output logic [3:0]                     position,
    output logic [3:0]                     path_city,
    output logic [bbps_pkg::LEN_W-1:0]     best_length,
    output logic [bbps_pkg::CNT_W-1:0]     cut_count,
    output logic                           last
);
    import bbps_pkg::*;

    localparam int CW  = $clog2(MAX_CITIES);       // city index width
    localparam int RW  = $clog2(MAX_CITIES + 1);   // rank / count width
    localparam int AW  = 2 * CW;
    localparam int EW  = 4 + DIST_BITS;            // table entry width
    localparam int SUM_W = (DIST_BITS > LEN_W ? DIST_BITS : LEN_W) + 1;

    // neighbour table: {to_city[3:0], distance}
    logic [EW-1:0] table_mem [2**AW];
    logic [EW-1:0] rd_data_reg;

    // configuration
    logic [4:0]       city_count_reg;
    logic [LEN_W-1:0] initial_bound_reg;

    // search state
    state_t            state_reg, state_next;
    logic [CW-1:0]     path_reg   [MAX_CITIES];
    logic [RW-1:0]     rank_reg   [MAX_CITIES];
    logic [LEN_W-1:0]  len_reg    [MAX_CITIES];
    logic [CW-1:0]     best_reg   [MAX_CITIES];
    logic [MAX_CITIES-1:0] visited_reg;
    logic [RW-1:0]     depth_reg;       // number of cities on path (1..n)
    logic [RW-1:0]     n_reg;           // clamped city count
    logic [LEN_W-1:0]  bestlen_reg;
    logic [CNT_W-1:0]  cut_reg;
    logic              found_reg;
    logic [RW-1:0]     emit_reg;

    // clamp of city_count
    logic [RW-1:0] n_clamp;
    always_comb
    begin
        if (city_count_reg < 5'd2)
            n_clamp = RW'(2);
        else if (32'(city_count_reg) > MAX_CITIES)
            n_clamp = RW'(MAX_CITIES);
        else
            n_clamp = RW'(city_count_reg);
    end

    // top of stack
    logic [CW-1:0]    top_city;
    logic [RW-1:0]    top_rank;
    logic [LEN_W-1:0] top_len;
    assign top_city = path_reg[CW'(depth_reg - RW'(1))];
    assign top_rank = rank_reg[CW'(depth_reg - RW'(1))];
    assign top_len  = len_reg[CW'(depth_reg - RW'(1))];

    // add/saturate/compare unit on the fetched entry
    logic [3:0]       e_to;
    logic [SUM_W-1:0] e_sum;
    logic [LEN_W-1:0] e_len;
    logic             e_skip;
    always_comb
    begin
        e_to   = rd_data_reg[EW-1 -: 4];
        e_sum  = SUM_W'(top_len) + SUM_W'(rd_data_reg[DIST_BITS-1:0]);
        e_len  = (e_sum > SUM_W'(LEN_MAX)) ? LEN_MAX : e_sum[LEN_W-1:0];
        e_skip = (RW'(e_to) >= n_reg) || (32'(e_to) >= MAX_CITIES)
                 || visited_reg[CW'(e_to)];
    end

    // table write / read port
    logic [AW-1:0] rd_addr;
    assign rd_addr = {top_city, top_rank[CW-1:0]};
    always_ff @(posedge clk)
    begin
        if (start && !busy && op == OP_LOAD
            && 32'(from_city) < MAX_CITIES && 32'(rank) < MAX_CITIES)
            table_mem[{from_city[CW-1:0], rank[CW-1:0]}]
                <= {to_city, DIST_BITS'(edge_length)};
        rd_data_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            city_count_reg    <= 5'd16;
            initial_bound_reg <= LEN_MAX;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_CITY_COUNT)
                city_count_reg <= cfg_data[4:0];
            else
                initial_bound_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start && op == OP_START)
                    state_next = (n_clamp == RW'(1)) ? ST_EMIT : ST_FETCH;
            ST_FETCH:
                if (top_rank >= n_reg)
                    state_next = (depth_reg == RW'(1)) ? ST_EMIT : ST_FETCH;
                else
                    state_next = ST_EXAM;
            ST_EXAM:
                state_next = ST_FETCH;
            ST_EMIT:
                if (!found_reg || emit_reg == n_reg - RW'(1))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // cut counter increment, saturating
    logic [CNT_W-1:0] cut_inc;
    assign cut_inc = (cut_reg == '1) ? cut_reg : cut_reg + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CITIES; i++)
            begin
                path_reg[i] <= '0;
                rank_reg[i] <= '0;
                len_reg[i]  <= '0;
                best_reg[i] <= '0;
            end
            visited_reg <= '0;
            depth_reg   <= '0;
            n_reg       <= RW'(2);
            bestlen_reg <= LEN_MAX;
            cut_reg     <= '0;
            found_reg   <= 1'b0;
            emit_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (start && op == OP_START)
                    begin
                        for (int i = 0; i < MAX_CITIES; i++)
                        begin
                            path_reg[i] <= '0;
                            rank_reg[i] <= '0;
                            len_reg[i]  <= '0;
                        end
                        visited_reg <= MAX_CITIES'(1);
                        depth_reg   <= RW'(1);
                        n_reg       <= n_clamp;
                        bestlen_reg <= initial_bound_reg;
                        emit_reg    <= '0;
                        // root: length 0 vs bound
                        if (initial_bound_reg == '0)
                        begin
                            cut_reg   <= CNT_W'(1);
                            found_reg <= 1'b0;
                            rank_reg[0] <= RW'(MAX_CITIES); // exhausted
                        end
                        else
                        begin
                            cut_reg   <= '0;
                            found_reg <= 1'b0;
                        end
                    end
                ST_FETCH:
                    if (top_rank >= n_reg)
                    begin
                        // backtrack
                        if (depth_reg != RW'(1))
                        begin
                            visited_reg[top_city] <= 1'b0;
                            depth_reg <= depth_reg - RW'(1);
                        end
                    end
                    else
                        rank_reg[CW'(depth_reg - RW'(1))] <= top_rank + RW'(1);
                ST_EXAM:
                    if (!e_skip)
                    begin
                        if (e_len >= bestlen_reg)
                            cut_reg <= cut_inc;
                        else if (depth_reg + RW'(1) == n_reg)
                        begin
                            bestlen_reg <= e_len;
                            found_reg   <= 1'b1;
                            for (int i = 0; i < MAX_CITIES; i++)
                                best_reg[i] <= path_reg[i];
                            best_reg[CW'(depth_reg)] <= CW'(e_to);
                            path_reg[CW'(depth_reg)] <= CW'(e_to);
                            len_reg[CW'(depth_reg)]  <= e_len;
                        end
                        else
                        begin
                            path_reg[CW'(depth_reg)] <= CW'(e_to);
                            len_reg[CW'(depth_reg)]  <= e_len;
                            rank_reg[CW'(depth_reg)] <= '0;
                            visited_reg[CW'(e_to)]   <= 1'b1;
                            depth_reg <= depth_reg + RW'(1);
                        end
                    end
                ST_EMIT:
                    emit_reg <= emit_reg + RW'(1);
                default:
                    ;
            endcase
        end
    end

    // outputs
    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_EMIT);
    assign found        = found_reg;
    assign position     = found_reg ? 4'(emit_reg) : 4'd0;
    assign path_city    = found_reg ? 4'(best_reg[CW'(emit_reg)]) : 4'd0;
    assign best_length  = bestlen_reg;
    assign cut_count    = cut_reg;
    assign last         = !found_reg || (emit_reg == n_reg - RW'(1));
endmodule
`default_nettype wire
